// ===== rtl/core/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Request and status codes, the datapath command and status bundles, and the
// fixed field widths of the request and result ports.
// ----------------------------------------------------------------------------
package chte_pkg;

  // Fixed field widths.
  localparam int KEY_W    = 64;
  localparam int BC_W     = 9;
  localparam int HANDLE_W = 9;
  localparam int COUNT_W  = 10;
  localparam int KEY_SHIFT = 3;
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;

  // The bucket reduction retires this many dividend bits per cycle.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOBUCKETS = 2'd3
  } status_e;

  // Slot table write operations.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_FILL_HEAD,
    WR_NEW,
    WR_LINK,
    WR_CLR_HEAD,
    WR_UNLINK_PREV,
    WR_PUSH_FREE
  } wr_e;

  typedef enum logic {
    RD_CUR,
    RD_FREE
  } rd_e;

  typedef enum logic [1:0] {
    H_ZERO,
    H_CUR,
    H_NEW
  } hsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    div_start;
    logic    div_step;
    logic    rd_en;
    rd_e     rd_sel;
    logic    latch_cur;
    logic    advance;
    wr_e     wr_op;
    logic    clr_step;
    logic    pop_free;
    logic    alloc_fresh;
    logic    push_free;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    respond;
    status_e resp_status;
    hsel_e   resp_hsel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nb_zero;
    logic bad_req;
    req_e req;
    logic div_done;
    logic clr_last;
    logic match;
    logic has_next;
    logic at_head;
    logic head_empty;
    logic free_valid;
    logic fresh_avail;
  } stat_t;

endpackage

// ===== rtl/core/chained_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_engine: hash table of 64-bit keys with chained buckets
// Finds, adds and removes keys; returns a slot handle, a status and the
// live entry count for each request.
// ----------------------------------------------------------------------------
// After reset the engine holds busy high while it clears all BUCKETS +
// POOL_SLOTS slots of the slot table, one slot per cycle. A request is taken
// when start is high and busy is low; its result appears for one cycle with
// result_valid_o, and the receiver cannot stall it. A rejected request (no
// buckets, reserved key, unknown type) is answered from the decode state.
// Otherwise the key is first reduced to its bucket four bits at a time, and
// each slot visited in the chain costs one read of the slot table RAM and one
// compare; an add that links a fresh pool slot writes the new slot and then
// links it, one from the free list is first read and popped, and a remove
// off the head unlinks the slot and pushes it onto the free list. The bucket
// count register may be written only while the engine is idle.
module chained_hash_table_engine #(
  parameter int BUCKETS    = 256,
  parameter int POOL_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [8:0]  handle_o,
  output logic [9:0]  entry_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);

  chte_pkg::cmd_t  cmd;
  chte_pkg::stat_t stat;
  logic            start_acc;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign start_acc   = start && !busy;

  // Request sequencer.
  chte_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_acc),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  // Table, counters and bucket reduction.
  chte_dp #(
    .BUCKETS    (BUCKETS),
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .handle_o      (handle_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ===== rtl/core/chte_ram.sv =====
// ----------------------------------------------------------------------------
// chte_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/chte_ctrl.sv =====
// ----------------------------------------------------------------------------
// chte_ctrl: request sequencer of the chained hash table engine
// Clears the table after reset, then walks each request through bucket
// reduction, the chain walk and the table updates.
// ----------------------------------------------------------------------------
module chte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  chte_pkg::stat_t  stat_i,
  output chte_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_FREE_RD,
    S_POP,
    S_WR_NEW,
    S_WR_LINK,
    S_UNLINK,
    S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_op    = chte_pkg::WR_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.nb_zero) begin
          cmd_o.respond     = 1'b1;
          cmd_o.resp_status = chte_pkg::ST_NOBUCKETS;
          cmd_o.resp_hsel   = chte_pkg::H_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.bad_req) begin
          cmd_o.respond     = 1'b1;
          cmd_o.resp_status = chte_pkg::ST_ABSENT;
          cmd_o.resp_hsel   = chte_pkg::H_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = chte_pkg::RD_CUR;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.latch_cur = 1'b1;
        if (stat_i.match) begin
          if (stat_i.req != chte_pkg::REQ_REMOVE) begin
            cmd_o.respond     = 1'b1;
            cmd_o.resp_status = chte_pkg::ST_OK;
            cmd_o.resp_hsel   = chte_pkg::H_CUR;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else if (stat_i.at_head) begin
            cmd_o.wr_op       = chte_pkg::WR_CLR_HEAD;
            cmd_o.cnt_dec     = 1'b1;
            cmd_o.respond     = 1'b1;
            cmd_o.resp_status = chte_pkg::ST_OK;
            cmd_o.resp_hsel   = chte_pkg::H_CUR;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_UNLINK;
          end
        end else if (stat_i.has_next) begin
          cmd_o.advance = 1'b1;
          state_d = S_READ;
        end else if (stat_i.req != chte_pkg::REQ_ADD) begin
          cmd_o.respond     = 1'b1;
          cmd_o.resp_status = chte_pkg::ST_ABSENT;
          cmd_o.resp_hsel   = chte_pkg::H_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.at_head && stat_i.head_empty) begin
          cmd_o.wr_op       = chte_pkg::WR_FILL_HEAD;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.respond     = 1'b1;
          cmd_o.resp_status = chte_pkg::ST_OK;
          cmd_o.resp_hsel   = chte_pkg::H_CUR;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.free_valid) begin
          state_d = S_FREE_RD;
        end else if (stat_i.fresh_avail) begin
          cmd_o.alloc_fresh = 1'b1;
          state_d = S_WR_NEW;
        end else begin
          cmd_o.respond     = 1'b1;
          cmd_o.resp_status = chte_pkg::ST_FULL;
          cmd_o.resp_hsel   = chte_pkg::H_ZERO;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = chte_pkg::RD_FREE;
        state_d = S_POP;
      end
      S_POP: begin
        cmd_o.pop_free = 1'b1;
        state_d = S_WR_NEW;
      end
      S_WR_NEW: begin
        cmd_o.wr_op = chte_pkg::WR_NEW;
        state_d = S_WR_LINK;
      end
      S_WR_LINK: begin
        cmd_o.wr_op       = chte_pkg::WR_LINK;
        cmd_o.cnt_inc     = 1'b1;
        cmd_o.respond     = 1'b1;
        cmd_o.resp_status = chte_pkg::ST_OK;
        cmd_o.resp_hsel   = chte_pkg::H_NEW;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_UNLINK: begin
        cmd_o.wr_op = chte_pkg::WR_UNLINK_PREV;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.wr_op       = chte_pkg::WR_PUSH_FREE;
        cmd_o.push_free   = 1'b1;
        cmd_o.cnt_dec     = 1'b1;
        cmd_o.respond     = 1'b1;
        cmd_o.resp_status = chte_pkg::ST_OK;
        cmd_o.resp_hsel   = chte_pkg::H_CUR;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the registered result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/chte_dp.sv =====
// ----------------------------------------------------------------------------
// chte_dp: datapath of the chained hash table engine
// Holds the slot table, the free list, the pool and entry counters, the
// bucket reduction unit and the result registers.
// ----------------------------------------------------------------------------
module chte_dp #(
  parameter int BUCKETS    = 256,
  parameter int POOL_SLOTS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        req_type_i,
  input  logic [chte_pkg::KEY_W-1:0]        key_i,
  input  logic                              cfg_valid_i,
  input  logic [chte_pkg::BC_W-1:0]         cfg_data_i,
  input  chte_pkg::cmd_t                    cmd_i,
  output chte_pkg::stat_t                   stat_o,
  output logic [1:0]                        status_o,
  output logic [chte_pkg::HANDLE_W-1:0]     handle_o,
  output logic [chte_pkg::COUNT_W-1:0]      entry_count_o
);

  localparam int TOTAL = BUCKETS + POOL_SLOTS;
  localparam int SW    = $clog2(TOTAL);
  localparam int WW    = chte_pkg::KEY_W + SW + 1;
  localparam int RW    = $clog2(2 * BUCKETS) + 1;
  localparam int FW    = $clog2(POOL_SLOTS + 1);
  localparam int LW    = $clog2(TOTAL + 1);
  localparam int KW    = chte_pkg::KEY_W;

  logic [chte_pkg::BC_W-1:0] bc_q;
  chte_pkg::req_e            req_q;
  logic [KW-1:0]             key_q;
  logic [KW-1:0]             dvd_q;
  logic [RW-1:0]             rem_q, rem_d;
  logic [chte_pkg::DIV_CW-1:0] dcnt_q;
  logic [RW-1:0]             nb;
  logic [31:0]               nb_w;
  logic [SW-1:0]             p_q, n_q, prev_q, clr_q, free_head_q;
  logic                      free_valid_q, at_head_q;
  logic [FW-1:0]             fresh_q;
  logic [LW-1:0]             live_q, live_d;
  logic [WW-1:0]             cur_q, prev_word_q;
  logic [1:0]                status_q;
  logic [chte_pkg::HANDLE_W-1:0] handle_q;
  logic [chte_pkg::COUNT_W-1:0]  entry_q;

  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [KW-1:0] rd_key;
  logic [SW-1:0] rd_next;
  logic          rd_has;

  // Slot table: {has_next, next, key} per slot.
  chte_ram #(
    .WIDTH (WW),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key  = rdata[KW-1:0];
  assign rd_next = rdata[KW +: SW];
  assign rd_has  = rdata[WW-1];

  assign raddr = (cmd_i.rd_sel == chte_pkg::RD_FREE) ? free_head_q : p_q;

  // Write address and data for each table update.
  always_comb begin
    we    = 1'b1;
    waddr = p_q;
    wdata = '0;
    case (cmd_i.wr_op)
      chte_pkg::WR_CLEAR: begin
        waddr = clr_q;
      end
      chte_pkg::WR_FILL_HEAD: begin
        wdata = {rd_has, rd_next, key_q};
      end
      chte_pkg::WR_NEW: begin
        waddr = n_q;
        wdata = {1'b0, {SW{1'b0}}, key_q};
      end
      chte_pkg::WR_LINK: begin
        wdata = {1'b1, n_q, cur_q[KW-1:0]};
      end
      chte_pkg::WR_CLR_HEAD: begin
        wdata = {rd_has, rd_next, {KW{1'b0}}};
      end
      chte_pkg::WR_UNLINK_PREV: begin
        waddr = prev_q;
        wdata = {cur_q[WW-1], cur_q[KW +: SW], prev_word_q[KW-1:0]};
      end
      chte_pkg::WR_PUSH_FREE: begin
        wdata = {free_valid_q, free_head_q, {KW{1'b0}}};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Buckets in use, capped at the number built.
  assign nb_w = (32'(bc_q) > 32'(BUCKETS)) ? 32'(BUCKETS) : 32'(bc_q);
  assign nb   = RW'(nb_w);

  // Restoring remainder, several dividend bits per cycle.
  always_comb begin
    logic [RW-1:0] r;
    logic [KW-1:0] dv;
    r  = rem_q;
    dv = dvd_q;
    for (int i = 0; i < chte_pkg::DIV_BITS; i++) begin
      r  = {r[RW-2:0], dv[KW-1]};
      dv = {dv[KW-2:0], 1'b0};
      if (r >= nb) begin
        r = r - nb;
      end
    end
    rem_d = r;
  end

  // Live entry count after this cycle's update.
  always_comb begin
    live_d = live_q;
    if (cmd_i.cnt_inc) begin
      live_d = live_q + LW'(1);
    end else if (cmd_i.cnt_dec) begin
      live_d = live_q - LW'(1);
    end
  end

  // Control registers: configuration, counters and free list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q         <= chte_pkg::BC_RESET;
      clr_q        <= '0;
      dcnt_q       <= '0;
      free_head_q  <= '0;
      free_valid_q <= 1'b0;
      fresh_q      <= '0;
      live_q       <= '0;
      at_head_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        bc_q <= cfg_data_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + SW'(1);
      end
      if (cmd_i.div_start) begin
        dcnt_q    <= '0;
        at_head_q <= 1'b1;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + chte_pkg::DIV_CW'(1);
      end
      if (cmd_i.advance) begin
        at_head_q <= 1'b0;
      end
      if (cmd_i.pop_free) begin
        free_head_q  <= rd_next;
        free_valid_q <= rd_has;
      end else if (cmd_i.push_free) begin
        free_head_q  <= p_q;
        free_valid_q <= 1'b1;
      end
      if (cmd_i.alloc_fresh) begin
        fresh_q <= fresh_q + FW'(1);
      end
      live_q <= live_d;
    end
  end

  // Request, walk and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= chte_pkg::req_e'(req_type_i);
      key_q <= key_i;
    end
    if (cmd_i.div_start) begin
      dvd_q <= key_q >> chte_pkg::KEY_SHIFT;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << chte_pkg::DIV_BITS;
      rem_q <= rem_d;
      if (dcnt_q == chte_pkg::DIV_CW'(chte_pkg::DIV_STEPS - 1)) begin
        p_q <= SW'(rem_d);
      end
    end
    if (cmd_i.latch_cur) begin
      cur_q <= rdata;
    end
    if (cmd_i.advance) begin
      prev_q      <= p_q;
      prev_word_q <= rdata;
      p_q         <= rd_next;
    end
    if (cmd_i.pop_free) begin
      n_q <= free_head_q;
    end else if (cmd_i.alloc_fresh) begin
      n_q <= SW'(32'(BUCKETS) + 32'(fresh_q));
    end
    if (cmd_i.respond) begin
      status_q <= cmd_i.resp_status;
      entry_q  <= chte_pkg::COUNT_W'(live_d);
      case (cmd_i.resp_hsel)
        chte_pkg::H_CUR: handle_q <= chte_pkg::HANDLE_W'(p_q);
        chte_pkg::H_NEW: handle_q <= chte_pkg::HANDLE_W'(n_q);
        default:         handle_q <= '0;
      endcase
    end
  end

  // Status toward the controller.
  assign stat_o.nb_zero     = (bc_q == '0);
  assign stat_o.bad_req     = (req_q == chte_pkg::REQ_NONE) || (key_q == '0);
  assign stat_o.req         = req_q;
  assign stat_o.div_done    = (dcnt_q == chte_pkg::DIV_CW'(chte_pkg::DIV_STEPS - 1));
  assign stat_o.clr_last    = (clr_q == SW'(TOTAL - 1));
  assign stat_o.match       = (rd_key == key_q);
  assign stat_o.has_next    = rd_has;
  assign stat_o.at_head     = at_head_q;
  assign stat_o.head_empty  = (rd_key == '0) && !rd_has;
  assign stat_o.free_valid  = free_valid_q;
  assign stat_o.fresh_avail = (32'(fresh_q) < 32'(POOL_SLOTS));

  assign status_o      = status_q;
  assign handle_o      = handle_q;
  assign entry_count_o = entry_q;

endmodule

// ===== rtl/core/chte_checker.sv =====
// ----------------------------------------------------------------------------
// chte_port_checker: port-level checks of the chained hash table engine
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module chte_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] status_o,
  input logic [8:0] handle_o
);

  // An accepted transaction keeps the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a request");

  // A result is delivered as the engine returns to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while engine busy");

  // Results never come in two consecutive cycles.
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  // A failed request carries a zero handle.
  a_fail_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != chte_pkg::ST_OK) |-> (handle_o == '0))
    else $error("nonzero handle on a failed request");

endmodule

bind chained_hash_table_engine chte_port_checker u_chte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .handle_o       (handle_o)
);

// ===== tb/chte_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chte_checker: scoreboard for the chained hash table engine
// Watches the request, result and configuration channels, keeps its own copy
// of the slot table and predicts each result, then compares it field by field.
// ----------------------------------------------------------------------------
module chte_checker #(
  parameter int BUCKETS    = 256,
  parameter int POOL_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_i,
  input  logic        result_valid_o,
  input  logic [1:0]  status_o,
  input  logic [8:0]  handle_o,
  input  logic [9:0]  entry_count_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int TOTAL = BUCKETS + POOL_SLOTS;

  typedef struct {
    chte_pkg::status_e status;
    logic [8:0]        handle;
    logic [9:0]        count;
  } answer_t;

  // Shadow copy of the table state.
  logic [63:0] tbl_key [TOTAL];
  int          tbl_next [TOTAL];
  logic        tbl_linked [TOTAL];
  int          free_top;
  logic        free_ok;
  int          fresh_idx;
  int          live_keys;
  logic [8:0]  bucket_reg;

  answer_t answers_q[$];
  int      fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = answers_q.size();

  task automatic report(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int succ(input int s);
    if (s >= TOTAL || !tbl_linked[s]) return TOTAL;
    return (tbl_next[s] < TOTAL) ? tbl_next[s] : TOTAL;
  endfunction

  // Applies one request to the shadow table and returns its answer.
  function automatic answer_t lookup_update(input chte_pkg::req_e req,
                                            input logic [63:0] key);
    answer_t a;
    int nb, head, p, prev, n, guard;
    logic hit;
    nb = (bucket_reg > BUCKETS) ? BUCKETS : int'(bucket_reg);
    a.handle = '0;
    if (nb == 0) begin
      a.status = chte_pkg::ST_NOBUCKETS;
    end else if (req == chte_pkg::REQ_NONE || key == 64'd0) begin
      a.status = chte_pkg::ST_ABSENT;
    end else begin
      head = int'((key >> chte_pkg::KEY_SHIFT) % 64'(nb));
      if (req == chte_pkg::REQ_FIND || req == chte_pkg::REQ_ADD) begin
        // Walk the head and the chain, remembering the tail.
        p = head;
        guard = 0;
        hit = 1'b0;
        while (1) begin
          if (tbl_key[p] == key) begin
            hit = 1'b1;
            break;
          end
          n = succ(p);
          guard++;
          if (n >= TOTAL || guard > TOTAL) break;
          p = n;
        end
        if (hit) begin
          a.status = chte_pkg::ST_OK;
          a.handle = 9'(p);
        end else if (req == chte_pkg::REQ_FIND) begin
          a.status = chte_pkg::ST_ABSENT;
        end else if (p == head && tbl_key[p] == 64'd0 && !tbl_linked[p]) begin
          tbl_key[p] = key;
          live_keys++;
          a.status = chte_pkg::ST_OK;
          a.handle = 9'(p);
        end else begin
          n = -1;
          if (free_ok && free_top < TOTAL) begin
            n = free_top;
            free_ok = tbl_linked[n];
            free_top = tbl_next[n];
          end else if (fresh_idx < POOL_SLOTS) begin
            n = BUCKETS + fresh_idx;
            fresh_idx++;
          end
          if (n < 0) begin
            a.status = chte_pkg::ST_FULL;
          end else begin
            tbl_key[n] = key;
            tbl_next[n] = 0;
            tbl_linked[n] = 1'b0;
            tbl_next[p] = n;
            tbl_linked[p] = 1'b1;
            live_keys++;
            a.status = chte_pkg::ST_OK;
            a.handle = 9'(n);
          end
        end
      end else if (tbl_key[head] == key) begin
        // Remove from the head; any chain stays in place.
        tbl_key[head] = 64'd0;
        live_keys--;
        a.status = chte_pkg::ST_OK;
        a.handle = 9'(head);
      end else begin
        a.status = chte_pkg::ST_ABSENT;
        prev = head;
        p = succ(head);
        guard = 0;
        while (p < TOTAL) begin
          guard++;
          if (guard > TOTAL) break;
          if (tbl_key[p] == key) begin
            // Unlink the slot and push it onto the free list.
            tbl_linked[prev] = tbl_linked[p];
            tbl_next[prev] = tbl_next[p];
            tbl_key[p] = 64'd0;
            tbl_next[p] = free_top;
            tbl_linked[p] = free_ok;
            free_top = p;
            free_ok = 1'b1;
            live_keys--;
            a.status = chte_pkg::ST_OK;
            a.handle = 9'(p);
            break;
          end
          prev = p;
          p = succ(p);
        end
      end
    end
    a.count = 10'(live_keys);
    return a;
  endfunction

  // Compare results first, then record the transaction accepted at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL; i++) begin
        tbl_key[i] = '0;
        tbl_next[i] = 0;
        tbl_linked[i] = 1'b0;
      end
      free_top = 0;
      free_ok = 1'b0;
      fresh_idx = 0;
      live_keys = 0;
      bucket_reg = chte_pkg::BC_RESET;
      answers_q.delete();
      fail_count = 0;
    end else begin
      if (result_valid_o) begin
        if (answers_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          exp_a = answers_q.pop_front();
          if (status_o != exp_a.status)
            report($sformatf("status %0d, expected %0d", status_o, exp_a.status));
          if (handle_o != exp_a.handle)
            report($sformatf("handle %0d, expected %0d", handle_o, exp_a.handle));
          if (entry_count_o != exp_a.count)
            report($sformatf("entry count %0d, expected %0d", entry_count_o, exp_a.count));
        end
      end
      if (start && !busy)
        answers_q.push_back(lookup_update(chte_pkg::req_e'(req_type_i), key_i));
      if (cfg_valid_i && cfg_ready_o)
        bucket_reg = cfg_data_i;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the chained hash table engine
// Drives find, add and remove requests in random bursts over several bucket
// counts, including zero and out-of-range values, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [63:0] key_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [8:0]  handle_o;
  logic [9:0]  entry_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic [63:0] recent_keys[$];

  always #5 clk_i = ~clk_i;

  chained_hash_table_engine u_dut (.*);

  chte_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .key_i, .result_valid_o,
    .status_o, .handle_o, .entry_count_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: counts cycles with no transaction on any channel.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drives one request and holds it until the engine takes it.
  task automatic send_req(input chte_pkg::req_e req, input logic [63:0] key);
    start <= 1'b1;
    req_type_i <= req;
    key_i <= key;
    if (req == chte_pkg::REQ_ADD && key != 0) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    end
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_buckets(input logic [8:0] bc);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= bc;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Keys mostly land in a few dozen buckets so that chains grow long.
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 64'd0;
    if (r < 45 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 52) return {$urandom, $urandom};
    return (((64'($urandom_range(0, 1023)) << 8) | 64'($urandom_range(0, 31))) << 3)
           | 64'($urandom_range(0, 7));
  endfunction

  task automatic random_phase(input logic [8:0] bc, input int count,
                              input int add_pct, input int rem_pct);
    int sent, burst, r;
    chte_pkg::req_e req;
    write_buckets(bc);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) req = chte_pkg::REQ_NONE;
        else if (r < 3 + add_pct) req = chte_pkg::REQ_ADD;
        else if (r < 3 + add_pct + rem_pct) req = chte_pkg::REQ_REMOVE;
        else req = chte_pkg::REQ_FIND;
        send_req(req, pick_key());
        sent++;
      end
      // Half the bursts run straight into the next one.
      if ($urandom_range(0, 1)) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the reset bucket count.
    send_req(chte_pkg::REQ_FIND, 64'd8);
    send_req(chte_pkg::REQ_ADD, 64'd8);
    send_req(chte_pkg::REQ_ADD, 64'd8);
    send_req(chte_pkg::REQ_ADD, 64'd8 + (64'd256 << 3));
    send_req(chte_pkg::REQ_ADD, 64'd8 + (64'd512 << 3));
    send_req(chte_pkg::REQ_FIND, 64'd8 + (64'd256 << 3));
    send_req(chte_pkg::REQ_REMOVE, 64'd8 + (64'd256 << 3));
    send_req(chte_pkg::REQ_REMOVE, 64'd8);
    send_req(chte_pkg::REQ_FIND, 64'd8 + (64'd512 << 3));
    send_req(chte_pkg::REQ_ADD, 64'd8 + (64'd768 << 3));
    send_req(chte_pkg::REQ_REMOVE, 64'd8 + (64'd999 << 3));
    send_req(chte_pkg::REQ_ADD, 64'd0);
    send_req(chte_pkg::REQ_FIND, 64'd0);
    send_req(chte_pkg::REQ_REMOVE, 64'd0);
    send_req(chte_pkg::REQ_NONE, 64'd16);
    send_req(chte_pkg::REQ_ADD, '1);
    send_req(chte_pkg::REQ_FIND, '1);
    send_req(chte_pkg::REQ_REMOVE, '1);
    send_req(chte_pkg::REQ_ADD, 64'h8000_0000_0000_0000);
    send_req(chte_pkg::REQ_FIND, 64'h8000_0000_0000_0000);

    random_phase(9'd256, 380, 55, 15);
    // Let every outstanding result come back before going on.
    wait_drained();
    random_phase(9'd300, 250, 75, 5);
    random_phase(9'd0, 30, 40, 30);
    random_phase(9'd1, 150, 70, 15);
    random_phase(9'd5, 300, 35, 35);
    random_phase(9'd511, 100, 40, 30);
    random_phase(9'd256, 330, 20, 55);

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/chte_pkg.sv
rtl/core/chte_ram.sv
rtl/core/chte_ctrl.sv
rtl/core/chte_dp.sv
rtl/core/chained_hash_table_engine.sv
rtl/core/chte_checker.sv
tb/chte_checker.sv
tb/tb_top.sv
